@@ rtl/spdo_pkg.sv @@
package spdo_pkg;

	localparam int FRAC_BITS         = 24;
	localparam int CORDIC_ITERATIONS = 24;
	localparam int ITER_W            = $clog2(CORDIC_ITERATIONS);

	localparam int LEN_W    = 16;
	localparam int TURN_W   = 20;
	localparam int XY_W     = 28;
	localparam int POS_W    = 29;
	localparam int HEAD_W   = 27;
	localparam int HSUM_W   = HEAD_W + 1;
	localparam int DTURN_W  = TURN_W + 2;
	localparam int MEAN_W   = LEN_W + 2;
	localparam int CORDIC_W = 27;
	localparam int PROD_W   = MEAN_W + CORDIC_W;
	localparam int SUM_W    = POS_W + 1;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 20;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STEP_LENGTH   = 1'b0,
		CFG_TURN_PER_STEP = 1'b1
	} cfg_idx_t;

	localparam logic [LEN_W-1:0]  STEP_LENGTH_RST   = 16'd1317;
	localparam logic [TURN_W-1:0] TURN_PER_STEP_RST = 20'd5268;

	localparam logic signed [HSUM_W-1:0]   PI_H      = 28'sd52707179;
	localparam logic signed [HSUM_W-1:0]   TWO_PI_H  = 28'sd105414358;
	localparam logic signed [CORDIC_W-1:0] PI_C      = 27'sd52707179;
	localparam logic signed [CORDIC_W-1:0] HALF_PI_C = 27'sd26353589;
	localparam logic signed [CORDIC_W-1:0] CORDIC_K  = 27'sd10188014;

	localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [SUM_W-1:0]  POS_MAX    = 30'sd268435455;
	localparam logic signed [SUM_W-1:0]  POS_MIN    = -30'sd268435456;

	typedef struct packed {
		logic                   operation;
		logic                   left_step;
		logic                   right_step;
		logic                   left_reverse;
		logic                   right_reverse;
		logic signed [XY_W-1:0]   new_x;
		logic signed [XY_W-1:0]   new_y;
		logic signed [HEAD_W-1:0] new_heading;
	} evt_t;

	typedef struct packed {
		logic              load;
		logic              wrap;
		logic              init;
		logic              rot;
		logic              mulx;
		logic              muly;
		logic              accy;
		logic              commit;
		logic [ITER_W-1:0] iter;
	} cmd_t;

	typedef struct packed {
		logic set_pose;
	} sts_t;

	// atan(2^-i) in 2^-24 rad, rounded to nearest
	function automatic logic signed [CORDIC_W-1:0] atan_lut(input logic [ITER_W-1:0] i);
		logic signed [CORDIC_W-1:0] v;
		begin
			case (i)
				5'd0:    v = 27'sd13176795;
				5'd1:    v = 27'sd7778716;
				5'd2:    v = 27'sd4110060;
				5'd3:    v = 27'sd2086331;
				5'd4:    v = 27'sd1047214;
				5'd5:    v = 27'sd524117;
				5'd6:    v = 27'sd262123;
				5'd7:    v = 27'sd131069;
				5'd8:    v = 27'sd65536;
				5'd9:    v = 27'sd32768;
				5'd10:   v = 27'sd16384;
				5'd11:   v = 27'sd8192;
				5'd12:   v = 27'sd4096;
				5'd13:   v = 27'sd2048;
				5'd14:   v = 27'sd1024;
				5'd15:   v = 27'sd512;
				5'd16:   v = 27'sd256;
				5'd17:   v = 27'sd128;
				5'd18:   v = 27'sd64;
				5'd19:   v = 27'sd32;
				5'd20:   v = 27'sd16;
				5'd21:   v = 27'sd8;
				5'd22:   v = 27'sd4;
				5'd23:   v = 27'sd2;
				default: v = '0;
			endcase
			return v;
		end
	endfunction

endpackage

@@ rtl/spdo_if.sv @@
interface spdo_evt_if;
	import spdo_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     operation;
	logic                     left_step;
	logic                     right_step;
	logic                     left_reverse;
	logic                     right_reverse;
	logic signed [XY_W-1:0]   new_x;
	logic signed [XY_W-1:0]   new_y;
	logic signed [HEAD_W-1:0] new_heading;

	modport source (output valid, operation, left_step, right_step, left_reverse,
		right_reverse, new_x, new_y, new_heading, input ready);
	modport sink (input valid, operation, left_step, right_step, left_reverse,
		right_reverse, new_x, new_y, new_heading, output ready);
endinterface

interface spdo_pose_if;
	import spdo_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [XY_W-1:0]   pose_x;
	logic signed [XY_W-1:0]   pose_y;
	logic signed [HEAD_W-1:0] pose_heading;

	modport source (output valid, pose_x, pose_y, pose_heading, input ready);
	modport sink (input valid, pose_x, pose_y, pose_heading, output ready);
endinterface

interface spdo_cfg_if;
	import spdo_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/spdo_ctrl.sv @@
module spdo_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          evt_valid,
	output logic          evt_ready,
	output logic          pose_valid,
	input  logic          pose_ready,
	input  spdo_pkg::sts_t sts,
	output spdo_pkg::cmd_t cmd
);
	import spdo_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_WRAP   = 8'b0000_0010,
		ST_INIT   = 8'b0000_0100,
		ST_ROT    = 8'b0000_1000,
		ST_MULX   = 8'b0001_0000,
		ST_MULY   = 8'b0010_0000,
		ST_ACCY   = 8'b0100_0000,
		ST_COMMIT = 8'b1000_0000
	} state_t;

	localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_ITERATIONS - 1);

	state_t            state_q, state_d;
	logic [ITER_W-1:0] iter_q;
	logic              out_valid_q;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.iter   = iter_q;
		unique case (state_q)
			ST_IDLE: begin
				if (evt_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_WRAP;
				end
			end
			ST_WRAP: begin
				cmd.wrap = 1'b1;
				state_d  = sts.set_pose ? ST_COMMIT : ST_INIT;
			end
			ST_INIT: begin
				cmd.init = 1'b1;
				state_d  = ST_ROT;
			end
			ST_ROT: begin
				cmd.rot = 1'b1;
				if (iter_q == ITER_LAST) state_d = ST_MULX;
			end
			ST_MULX: begin
				cmd.mulx = 1'b1;
				state_d  = ST_MULY;
			end
			ST_MULY: begin
				cmd.muly = 1'b1;
				state_d  = ST_ACCY;
			end
			ST_ACCY: begin
				cmd.accy = 1'b1;
				state_d  = ST_COMMIT;
			end
			ST_COMMIT: begin
				// hold until the result slot is free
				if (!out_valid_q || pose_ready) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.init)     iter_q <= '0;
			else if (cmd.rot) iter_q <= iter_q + ITER_W'(1);
			if (cmd.commit)      out_valid_q <= 1'b1;
			else if (pose_ready) out_valid_q <= 1'b0;
		end
	end

	assign evt_ready  = (state_q == ST_IDLE);
	assign pose_valid = out_valid_q;

	a_load_to_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_WRAP)
		else $error("item load not followed by wrap");

	a_rot_full: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MULX |-> $past(state_q) == ST_ROT && $past(iter_q) == ITER_LAST)
		else $error("multiply entered before all rotations");

	a_set_skips: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMMIT && sts.set_pose) |->
		($past(state_q) == ST_WRAP || $past(state_q) == ST_COMMIT))
		else $error("set pose went through the rotation path");

	a_valid_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_COMMIT)
		else $error("result shown without commit");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !pose_ready) |-> !cmd.commit)
		else $error("pending item overwritten");
endmodule

@@ rtl/spdo_dp.sv @@
module spdo_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  spdo_pkg::cmd_t                      cmd,
	output spdo_pkg::sts_t                      sts,
	input  spdo_pkg::evt_t                      evt_data,
	input  logic                                cfg_we,
	input  logic [spdo_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [spdo_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic signed [spdo_pkg::XY_W-1:0]    pose_x,
	output logic signed [spdo_pkg::XY_W-1:0]    pose_y,
	output logic signed [spdo_pkg::HEAD_W-1:0]  pose_heading
);
	import spdo_pkg::*;

	// architectural state
	logic [LEN_W-1:0]           step_len_q;
	logic [TURN_W-1:0]          turn_q;
	logic signed [POS_W-1:0]    pos_x_q, pos_y_q;
	logic signed [HEAD_W-1:0]   heading_q;

	// working registers
	logic                       op_q;
	logic signed [XY_W-1:0]     set_x_q, set_y_q;
	logic signed [HSUM_W-1:0]   hsum_q;
	logic signed [HEAD_W-1:0]   hnew_q;
	logic signed [MEAN_W-1:0]   mean_q;
	logic signed [CORDIC_W-1:0] x_q, y_q, z_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [POS_W-1:0]    nx_q, ny_q;

	// load: wheel travel and raw heading
	logic signed [MEAN_W-1:0]   len_ext, trav_l, trav_r, mean_d;
	logic signed [DTURN_W-1:0]  turn_ext, turn_l, turn_r, dturn;
	logic signed [HSUM_W-1:0]   hsum_d;

	always_comb begin
		len_ext  = MEAN_W'(step_len_q);
		trav_l   = evt_data.left_step  ? (evt_data.left_reverse  ? -len_ext : len_ext) : '0;
		trav_r   = evt_data.right_step ? (evt_data.right_reverse ? -len_ext : len_ext) : '0;
		mean_d   = trav_l + trav_r;
		turn_ext = DTURN_W'(turn_q);
		turn_l   = evt_data.left_step  ? (evt_data.left_reverse  ? -turn_ext : turn_ext) : '0;
		turn_r   = evt_data.right_step ? (evt_data.right_reverse ? -turn_ext : turn_ext) : '0;
		dturn    = turn_r - turn_l;
		hsum_d   = evt_data.operation ? HSUM_W'(evt_data.new_heading)
		                              : HSUM_W'(heading_q) + HSUM_W'(dturn);
	end

	// heading wrap into [-pi, pi]; one correction covers every reachable sum
	logic signed [HSUM_W-1:0] hwrap;

	always_comb begin
		if (hsum_q > PI_H)       hwrap = hsum_q - TWO_PI_H;
		else if (hsum_q < -PI_H) hwrap = hsum_q + TWO_PI_H;
		else                     hwrap = hsum_q;
	end

	// CORDIC rotation step
	logic signed [CORDIC_W-1:0] xs, ys, atan_v;

	always_comb begin
		xs     = x_q >>> cmd.iter;
		ys     = y_q >>> cmd.iter;
		atan_v = atan_lut(cmd.iter);
	end

	// shared multiplier, rounding and saturating accumulate
	logic signed [CORDIC_W-1:0] mul_op;
	logic signed [PROD_W-1:0]   prod_d, rnd_full;
	logic signed [POS_W-1:0]    pos_sel, pos_sat;
	logic signed [SUM_W-1:0]    sum_w;

	always_comb begin
		mul_op   = cmd.muly ? y_q : x_q;
		prod_d   = mean_q * mul_op;
		rnd_full = (prod_q + ROUND_HALF) >>> FRAC_BITS;
		pos_sel  = cmd.accy ? pos_y_q : pos_x_q;
		sum_w    = SUM_W'(pos_sel) + $signed(rnd_full[SUM_W-1:0]);
		if (sum_w > POS_MAX)      pos_sat = POS_MAX[POS_W-1:0];
		else if (sum_w < POS_MIN) pos_sat = POS_MIN[POS_W-1:0];
		else                      pos_sat = sum_w[POS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_len_q <= STEP_LENGTH_RST;
			turn_q     <= TURN_PER_STEP_RST;
			pos_x_q    <= '0;
			pos_y_q    <= '0;
			heading_q  <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_STEP_LENGTH:   step_len_q <= cfg_data[LEN_W-1:0];
					CFG_TURN_PER_STEP: turn_q     <= cfg_data[TURN_W-1:0];
					default: ;
				endcase
			end
			if (cmd.commit) begin
				heading_q <= hnew_q;
				if (op_q) begin
					pos_x_q <= {set_x_q, 1'b0};
					pos_y_q <= {set_y_q, 1'b0};
				end else begin
					pos_x_q <= nx_q;
					pos_y_q <= ny_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= evt_data.operation;
			set_x_q <= evt_data.new_x;
			set_y_q <= evt_data.new_y;
			mean_q  <= mean_d;
			hsum_q  <= hsum_d;
		end
		if (cmd.wrap) hnew_q <= hwrap[HEAD_W-1:0];
		if (cmd.init) begin
			// fold into [-pi/2, pi/2]; the sign flip rides on the travel
			x_q <= CORDIC_K;
			y_q <= '0;
			if (hnew_q > HALF_PI_C) begin
				z_q    <= hnew_q - PI_C;
				mean_q <= -mean_q;
			end else if (hnew_q < -HALF_PI_C) begin
				z_q    <= hnew_q + PI_C;
				mean_q <= -mean_q;
			end else begin
				z_q <= hnew_q;
			end
		end
		if (cmd.rot) begin
			if (!z_q[CORDIC_W-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_v;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_v;
			end
		end
		if (cmd.mulx || cmd.muly) prod_q <= prod_d;
		if (cmd.muly) nx_q <= pos_sat;
		if (cmd.accy) ny_q <= pos_sat;
	end

	assign sts.set_pose  = op_q;
	assign pose_x        = pos_x_q[POS_W-1:1];
	assign pose_y        = pos_y_q[POS_W-1:1];
	assign pose_heading  = heading_q;
endmodule

@@ rtl/step_pulse_differential_odometry.sv @@
// Differential-drive odometry from stepper step events. Each evt item is either a step
// event (step and reverse flags per wheel) or a set-pose load; every item returns the
// pose after it on the pose channel (x, y in 2^-24 m, saturating at +-8 m; heading in
// 2^-24 rad, wrapped into [-pi, pi]). One item is processed at a time: a step event goes
// through load, wrap, init, the 24-round CORDIC that shares one rotation stage, one round
// per cycle, then multiply x, multiply y, accumulate y and commit; a set-pose item goes from
// wrap straight to commit. The next item is taken in the cycle after the result is
// committed; a result not yet taken holds the commit. A finished pose waits in the output
// register while the next item is accepted and worked on. step_length and turn_per_step
// are written over cfg (index 0 and 1); the user must write them only while the block is
// idle, which the block itself does not enforce; cfg is always ready.
module step_pulse_differential_odometry (
	input logic         clk,
	input logic         arst_n,
	spdo_evt_if.sink    evt,
	spdo_pose_if.source pose,
	spdo_cfg_if.sink    cfg
);
	import spdo_pkg::*;

	cmd_t cmd;
	sts_t sts;
	evt_t evt_data;

	assign evt_data = '{
		operation:     evt.operation,
		left_step:     evt.left_step,
		right_step:    evt.right_step,
		left_reverse:  evt.left_reverse,
		right_reverse: evt.right_reverse,
		new_x:         evt.new_x,
		new_y:         evt.new_y,
		new_heading:   evt.new_heading
	};

	assign cfg.ready = 1'b1;

	spdo_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.evt_valid  (evt.valid),
		.evt_ready  (evt.ready),
		.pose_valid (pose.valid),
		.pose_ready (pose.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	spdo_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.evt_data     (evt_data),
		.cfg_we       (cfg.valid),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.pose_x       (pose.pose_x),
		.pose_y       (pose.pose_y),
		.pose_heading (pose.pose_heading)
	);
endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
	import spdo_pkg::*;

	localparam longint PI_FX      = 52707179;
	localparam longint HALF_PI_FX = PI_FX >>> 1;
	localparam longint GAIN_FX    = 10188014;
	localparam longint unsigned PI_Q48 = 64'h3243F6A8885A3;
	localparam longint CLAMP_HI   = 268435455;
	localparam longint CLAMP_LO   = -268435456;
	localparam longint X_TOP      = 134217727;
	localparam longint X_BOT      = -134217728;
	localparam longint HEAD_TOP   = 67108863;
	localparam longint HEAD_BOT   = -67108864;
	localparam longint LEN_RST    = 1317;
	localparam longint TURN_RST   = 5268;
	localparam int     SETTLE     = 40;
	localparam int     LIMIT      = 600000;

	class odometry_tracker;
		typedef struct packed {
			logic signed [XY_W-1:0]   x;
			logic signed [XY_W-1:0]   y;
			logic signed [HEAD_W-1:0] h;
		} pose_t;

		longint atan_q[CORDIC_ITERATIONS];
		longint x2, y2, hd, len, turn;
		pose_t  due_poses[$];
		int     mismatches;
		int     checked;

		function new();
			longint unsigned q, t;
			int e, k;
			for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
				if (i == 0) begin
					q = PI_Q48 << 10;
				end else begin
					q = 0;
					k = 0;
					e = 60 - i;
					while (e >= 0) begin
						t = (64'd1 << e) / 64'(2 * k + 1);
						if (k % 2)
							q -= t;
						else
							q += t;
						k++;
						e = 60 - i * (2 * k + 1);
					end
				end
				atan_q[i] = longint'((q + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS));
			end
			x2 = 0;
			y2 = 0;
			hd = 0;
			len = LEN_RST;
			turn = TURN_RST;
			mismatches = 0;
			checked = 0;
		endfunction

		function longint wrap(input longint a);
			while (a > PI_FX)
				a -= 2 * PI_FX;
			while (a < -PI_FX)
				a += 2 * PI_FX;
			return a;
		endfunction

		function longint clamp(input longint v);
			if (v > CLAMP_HI)
				return CLAMP_HI;
			if (v < CLAMP_LO)
				return CLAMP_LO;
			return v;
		endfunction

		function longint scale(input longint m, input longint t);
			return (m * t + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
		endfunction

		function void rotate(input longint ang, output longint c, output longint s);
			longint xr, yr, zr, xs, ys;
			bit flip;
			xr = GAIN_FX;
			yr = 0;
			zr = ang;
			flip = 1'b0;
			if (zr > HALF_PI_FX) begin
				zr -= PI_FX;
				flip = 1'b1;
			end else if (zr < -HALF_PI_FX) begin
				zr += PI_FX;
				flip = 1'b1;
			end
			for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
				xs = xr >>> i;
				ys = yr >>> i;
				if (zr >= 0) begin
					xr -= ys;
					yr += xs;
					zr -= atan_q[i];
				end else begin
					xr += ys;
					yr -= xs;
					zr += atan_q[i];
				end
			end
			c = flip ? -xr : xr;
			s = flip ? -yr : yr;
		endfunction

		function void set_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] d);
			case (idx)
				CFG_STEP_LENGTH:   len = longint'(d[LEN_W-1:0]);
				CFG_TURN_PER_STEP: turn = longint'(d[TURN_W-1:0]);
				default: ;
			endcase
		endfunction

		function void note_event(input evt_t e);
			longint sl, sr, travel, c, s;
			pose_t p;
			if (e.operation) begin
				x2 = 2 * longint'(e.new_x);
				y2 = 2 * longint'(e.new_y);
				hd = wrap(longint'(e.new_heading));
			end else begin
				sl = 0;
				sr = 0;
				if (e.left_step)
					sl = e.left_reverse ? -1 : 1;
				if (e.right_step)
					sr = e.right_reverse ? -1 : 1;
				hd = wrap(hd + (sr - sl) * turn);
				travel = (sl + sr) * len;
				rotate(hd, c, s);
				x2 = clamp(x2 + scale(travel, c));
				y2 = clamp(y2 + scale(travel, s));
			end
			p.x = XY_W'(x2 >>> 1);
			p.y = XY_W'(y2 >>> 1);
			p.h = HEAD_W'(hd);
			due_poses.push_back(p);
		endfunction

		function int pending();
			return due_poses.size();
		endfunction

		task report_mismatch(input string what);
			mismatches++;
			$display("mismatch: %s", what);
		endtask

		task check_pose(input logic signed [XY_W-1:0] x, input logic signed [XY_W-1:0] y,
				input logic signed [HEAD_W-1:0] h);
			pose_t p;
			if (due_poses.size() == 0) begin
				report_mismatch($sformatf("unexpected pose x=%0d y=%0d h=%0d", x, y, h));
				return;
			end
			p = due_poses.pop_front();
			if (x !== p.x)
				report_mismatch($sformatf("pose %0d x got %0d want %0d", checked, x, p.x));
			if (y !== p.y)
				report_mismatch($sformatf("pose %0d y got %0d want %0d", checked, y, p.y));
			if (h !== p.h)
				report_mismatch($sformatf("pose %0d heading got %0d want %0d", checked, h, p.h));
			checked++;
		endtask
	endclass

	logic clk;
	logic arst_n;
	bit   steady;
	int unsigned stall_left;
	int   cycle_count;
	odometry_tracker tracker;

	spdo_evt_if  evt_ch ();
	spdo_pose_if pose_ch ();
	spdo_cfg_if  cfg_ch ();

	step_pulse_differential_odometry dut (
		.clk   (clk),
		.arst_n(arst_n),
		.evt   (evt_ch),
		.pose  (pose_ch),
		.cfg   (cfg_ch)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && pose_ch.valid === 1'b1 && pose_ch.ready === 1'b1)
			tracker.check_pose(pose_ch.pose_x, pose_ch.pose_y, pose_ch.pose_heading);
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			pose_ch.ready <= 1'b0;
		end else if (!steady && $urandom_range(0, 999) < 2) begin
			stall_left <= $urandom_range(1, 60);
			pose_ch.ready <= 1'b0;
		end else if (!steady && $urandom_range(0, 99) < 3) begin
			pose_ch.ready <= 1'b0;
		end else begin
			pose_ch.ready <= 1'b1;
		end
	end

	function automatic evt_t step_evt(input bit l, input bit r, input bit lrev, input bit rrev);
		evt_t e;
		e.operation = 1'b0;
		e.left_step = l;
		e.right_step = r;
		e.left_reverse = lrev;
		e.right_reverse = rrev;
		e.new_x = XY_W'($urandom);
		e.new_y = XY_W'($urandom);
		e.new_heading = HEAD_W'($urandom);
		return e;
	endfunction

	function automatic evt_t pose_evt(input longint x, input longint y, input longint h);
		evt_t e;
		e.operation = 1'b1;
		{e.left_step, e.right_step, e.left_reverse, e.right_reverse} = 4'($urandom);
		e.new_x = XY_W'(x);
		e.new_y = XY_W'(y);
		e.new_heading = HEAD_W'(h);
		return e;
	endfunction

	function automatic longint near_edge();
		longint off;
		off = longint'($urandom_range(0, 300000));
		return $urandom_range(0, 1) ? X_TOP - off : X_BOT + off;
	endfunction

	function automatic evt_t random_event();
		logic [95:0] r;
		evt_t e;
		r = {$urandom, $urandom, $urandom};
		e = r[$bits(evt_t)-1:0];
		e.operation = 1'b0;
		if ($urandom_range(0, 99) < 15) begin
			e.operation = 1'b1;
			if ($urandom_range(0, 3) == 0) begin
				e.new_x = XY_W'(near_edge());
				e.new_y = XY_W'(near_edge());
			end
			if ($urandom_range(0, 3) != 0)
				e.new_heading = HEAD_W'(longint'($urandom_range(0, 32'(2 * PI_FX))) - PI_FX);
		end
		return e;
	endfunction

	task automatic send_event(input evt_t e);
		evt_ch.valid <= 1'b1;
		evt_ch.operation <= e.operation;
		evt_ch.left_step <= e.left_step;
		evt_ch.right_step <= e.right_step;
		evt_ch.left_reverse <= e.left_reverse;
		evt_ch.right_reverse <= e.right_reverse;
		evt_ch.new_x <= e.new_x;
		evt_ch.new_y <= e.new_y;
		evt_ch.new_heading <= e.new_heading;
		@(posedge clk);
		while (evt_ch.ready !== 1'b1)
			@(posedge clk);
		tracker.note_event(e);
	endtask

	task automatic idle_sender();
		if (!steady && $urandom_range(0, 99) < 15) begin
			evt_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
	endtask

	task automatic run_random(input int count);
		for (int i = 0; i < count; i++) begin
			idle_sender();
			send_event(random_event());
		end
	endtask

	task automatic wait_results();
		evt_ch.valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	task automatic drain();
		wait_results();
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] d);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= d;
		@(posedge clk);
		while (cfg_ch.ready !== 1'b1)
			@(posedge clk);
		tracker.set_register(idx, d);
	endtask

	task automatic program_registers(input logic [CFG_DATA_W-1:0] len_data,
			input logic [CFG_DATA_W-1:0] turn_data);
		write_register(CFG_STEP_LENGTH, len_data);
		write_register(CFG_TURN_PER_STEP, turn_data);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic run_directed();
		send_event(step_evt(1'b0, 1'b0, 1'b0, 1'b0));
		send_event(step_evt(1'b0, 1'b0, 1'b1, 1'b1));  // reverse flags alone do nothing
		send_event(step_evt(1'b1, 1'b1, 1'b0, 1'b0));
		send_event(step_evt(1'b1, 1'b1, 1'b1, 1'b1));
		send_event(step_evt(1'b0, 1'b1, 1'b0, 1'b0));
		send_event(step_evt(1'b1, 1'b0, 1'b0, 1'b0));
		send_event(step_evt(1'b1, 1'b0, 1'b1, 1'b0));
		send_event(step_evt(1'b0, 1'b1, 1'b0, 1'b1));
		send_event(step_evt(1'b1, 1'b1, 1'b1, 1'b0));
		send_event(step_evt(1'b1, 1'b1, 1'b0, 1'b1));
		// saturation at both ends of x and the top of y
		send_event(pose_evt(X_TOP, X_BOT, 0));
		send_event(step_evt(1'b1, 1'b1, 1'b0, 1'b0));
		send_event(pose_evt(X_BOT, X_TOP, PI_FX));
		send_event(step_evt(1'b1, 1'b1, 1'b0, 1'b0));
		send_event(pose_evt(0, X_TOP, HALF_PI_FX));
		send_event(step_evt(1'b1, 1'b1, 1'b0, 1'b0));
		// heading wraps past +pi and -pi
		send_event(pose_evt(0, 0, PI_FX - 1));
		send_event(step_evt(1'b1, 1'b1, 1'b1, 1'b0));
		send_event(pose_evt(0, 0, -PI_FX));
		send_event(step_evt(1'b1, 1'b1, 1'b0, 1'b1));
		// loaded heading outside [-pi, pi]
		send_event(pose_evt(-1, -1, HEAD_TOP));
		send_event(pose_evt(X_BOT, X_TOP, HEAD_BOT));
		send_event(step_evt(1'b1, 1'b1, 1'b0, 1'b0));
		send_event(pose_evt(0, 0, 0));
	endtask

	initial begin
		arst_n = 1'b0;
		steady = 1'b0;
		stall_left = 0;
		evt_ch.valid = 1'b0;
		evt_ch.operation = 1'b0;
		evt_ch.left_step = 1'b0;
		evt_ch.right_step = 1'b0;
		evt_ch.left_reverse = 1'b0;
		evt_ch.right_reverse = 1'b0;
		evt_ch.new_x = '0;
		evt_ch.new_y = '0;
		evt_ch.new_heading = '0;
		pose_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_STEP_LENGTH;
		cfg_ch.data = '0;
		tracker = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		run_random(50);
		wait_results();
		run_random(50);
		drain();

		program_registers(CFG_DATA_W'(16'hFFFF), CFG_DATA_W'(20'hFFFFF));
		run_random(150);
		drain();

		program_registers(CFG_DATA_W'(1), CFG_DATA_W'(1));
		run_random(100);
		drain();

		program_registers(CFG_DATA_W'(0), CFG_DATA_W'(20'hFFFFF));
		run_random(30);
		drain();

		program_registers(CFG_DATA_W'(16'hFFFF), CFG_DATA_W'(0));
		run_random(40);
		drain();

		program_registers(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
		run_random(150);
		drain();

		program_registers(CFG_DATA_W'(LEN_RST), CFG_DATA_W'(TURN_RST));
		steady = 1'b1;
		run_random(60);
		steady = 1'b0;
		run_random(40);
		drain();

		if (tracker.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
